// ===== rtl/core/fibmp_pkg.sv =====
// fibmp_pkg: modulus, microcode word format, program rom and modular helpers
package fibmp_pkg;

  localparam int unsigned PC_W = 5;

  localparam logic [30:0] FIB_P = 31'h7fff_ffff;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_MUL,
    ACT_COMMIT_ACC,
    ACT_COMMIT_PW,
    ACT_SHIFT,
    ACT_DONE
  } act_t;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_EVEN,
    COND_EZERO
  } cond_t;

  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic [2:0]      xsel;
    logic [2:0]      ysel;
    logic            second;
    logic [1:0]      dest;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic       vld;
    logic       second;
    logic [1:0] dest;
  } pipe_t;

  localparam logic [PC_W-1:0] STEP_CHECK      = 5'd0;
  localparam logic [PC_W-1:0] STEP_MUL_A      = 5'd1;
  localparam logic [PC_W-1:0] STEP_COMMIT_ACC = 5'd12;
  localparam logic [PC_W-1:0] STEP_SHIFT      = 5'd13;
  localparam logic [PC_W-1:0] STEP_TEST       = 5'd14;
  localparam logic [PC_W-1:0] STEP_MUL_P      = 5'd15;
  localparam logic [PC_W-1:0] STEP_COMMIT_PW  = 5'd26;
  localparam logic [PC_W-1:0] STEP_DONE       = 5'd27;
  localparam logic [PC_W-1:0] MUL_COUNT       = 5'd8;

  // operand selects: 0..3 acc entries, 4..7 pw entries, row-major
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t          w;
    logic [PC_W-1:0] off;
    logic [2:0]      k;
    logic            src;
    logic            is_mul;
    w = '{act: ACT_NOP, cond: COND_NONE, xsel: 3'd0, ysel: 3'd0,
          second: 1'b0, dest: 2'd0, target: STEP_CHECK};
    off = '0;
    src = 1'b0;
    is_mul = 1'b0;
    if (pc >= STEP_MUL_A && pc < STEP_MUL_A + MUL_COUNT) begin
      off = pc - STEP_MUL_A;
      src = 1'b0;
      is_mul = 1'b1;
    end else if (pc >= STEP_MUL_P && pc < STEP_MUL_P + MUL_COUNT) begin
      off = pc - STEP_MUL_P;
      src = 1'b1;
      is_mul = 1'b1;
    end
    k = off[2:0];
    if (is_mul) begin
      w.act    = ACT_MUL;
      w.xsel   = {src, k[2], k[0]};
      w.ysel   = {1'b1, k[0], k[1]};
      w.second = k[0];
      w.dest   = k[2:1];
    end else begin
      case (pc)
        STEP_CHECK: begin
          w.cond   = COND_EVEN;
          w.target = STEP_SHIFT;
        end
        STEP_COMMIT_ACC: w.act = ACT_COMMIT_ACC;
        STEP_SHIFT:      w.act = ACT_SHIFT;
        STEP_TEST: begin
          w.cond   = COND_EZERO;
          w.target = STEP_DONE;
        end
        STEP_COMMIT_PW: begin
          w.act    = ACT_COMMIT_PW;
          w.cond   = COND_ALWAYS;
          w.target = STEP_CHECK;
        end
        STEP_DONE: w.act = ACT_DONE;
        default:   w.act = ACT_NOP;
      endcase
    end
    return w;
  endfunction

  // 62-bit product folded mod 2^31-1, sum of halves stays below 2p
  function automatic logic [30:0] mod_fold(input logic [61:0] p);
    logic [31:0] s;
    s = {1'b0, p[30:0]} + {1'b0, p[61:31]};
    return (s >= {1'b0, FIB_P}) ? 31'(s - {1'b0, FIB_P}) : s[30:0];
  endfunction

  function automatic logic [30:0] mod_add(input logic [30:0] a, input logic [30:0] b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, FIB_P}) ? 31'(s - {1'b0, FIB_P}) : s[30:0];
  endfunction

endpackage

// ===== rtl/core/fibonacci_mod_prime_matrix_power.sv =====
// fibonacci_mod_prime_matrix_power: F(n) mod 2^31-1 by microcoded matrix square-and-multiply
// one item at a time: in_ready returns with out_valid, so no new index is taken while one is in work
// n = 0 or 1: goes straight to the done step, which loads the result once any earlier result is taken
// all products go through the one shared 31x31 multiplier, eight per matrix product
// rst_n synchronous active low: clears sequencer, pipeline valids and output valid
module fibonacci_mod_prime_matrix_power #(
  parameter int unsigned INDEX_BITS = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [30:0]           out_fib_value
);

  logic                        busy_r, busy_nxt;
  logic [fibmp_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [30:0]                 out_fib_value_r;
  logic                        out_load;
  fibmp_pkg::pipe_t            pipe1_r, pipe2_r, pipe3_r, pipe1_nxt;
  fibmp_pkg::ucode_t           uc;

  logic [INDEX_BITS-1:0]       e_r;
  logic [30:0]                 acc_r [4];
  logic [30:0]                 pw_r  [4];
  logic [30:0]                 nw_r  [4];
  logic [30:0]                 opx_r, opy_r, red_r, t_r;
  logic [61:0]                 prod_r;
  logic [30:0]                 opx_sel, opy_sel;
  logic                        accept, idx_trivial, jump;

  assign accept        = in_valid && in_ready;
  assign idx_trivial   = (in_index[INDEX_BITS-1:1] == '0);
  assign in_ready      = !busy_r;
  assign out_valid     = out_valid_r;
  assign out_fib_value = out_fib_value_r;

  assign opx_sel = uc.xsel[2] ? pw_r[uc.xsel[1:0]] : acc_r[uc.xsel[1:0]];
  assign opy_sel = uc.ysel[2] ? pw_r[uc.ysel[1:0]] : acc_r[uc.ysel[1:0]];

  always_comb begin
    uc            = fibmp_pkg::ucode_rom(pc_r);
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    jump          = (uc.cond == fibmp_pkg::COND_ALWAYS) ||
                    ((uc.cond == fibmp_pkg::COND_EVEN) && !e_r[0]) ||
                    ((uc.cond == fibmp_pkg::COND_EZERO) && (e_r == '0));
    pipe1_nxt.vld    = busy_r && (uc.act == fibmp_pkg::ACT_MUL);
    pipe1_nxt.second = uc.second;
    pipe1_nxt.dest   = uc.dest;
    if (accept) begin
      busy_nxt = 1'b1;
      pc_nxt   = idx_trivial ? fibmp_pkg::STEP_DONE : fibmp_pkg::STEP_CHECK;
    end else if (busy_r) begin
      case (uc.act)
        fibmp_pkg::ACT_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_load      = 1'b1;
            out_valid_nxt = 1'b1;
            busy_nxt      = 1'b0;
          end
        end
        default: pc_nxt = jump ? uc.target : pc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= fibmp_pkg::STEP_CHECK;
      out_valid_r <= 1'b0;
      pipe1_r     <= '0;
      pipe2_r     <= '0;
      pipe3_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      pipe1_r     <= pipe1_nxt;
      pipe2_r     <= pipe1_r;
      pipe3_r     <= pipe2_r;
    end
  end

  // datapath: operand fetch, multiply, fold, accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      e_r      <= in_index - 1'b1;
      acc_r[0] <= (in_index == '0) ? 31'd0 : 31'd1;
      acc_r[1] <= 31'd0;
      acc_r[2] <= 31'd0;
      acc_r[3] <= 31'd1;
      pw_r[0]  <= 31'd1;
      pw_r[1]  <= 31'd1;
      pw_r[2]  <= 31'd1;
      pw_r[3]  <= 31'd0;
    end else if (busy_r) begin
      case (uc.act)
        fibmp_pkg::ACT_SHIFT:      e_r  <= e_r >> 1;
        fibmp_pkg::ACT_COMMIT_ACC: acc_r <= nw_r;
        fibmp_pkg::ACT_COMMIT_PW:  pw_r  <= nw_r;
        default: ;
      endcase
    end
    opx_r  <= opx_sel;
    opy_r  <= opy_sel;
    prod_r <= 62'(opx_r) * 62'(opy_r);
    red_r  <= fibmp_pkg::mod_fold(prod_r);
    if (pipe3_r.vld) begin
      if (!pipe3_r.second) begin
        t_r <= red_r;
      end else begin
        nw_r[pipe3_r.dest] <= fibmp_pkg::mod_add(t_r, red_r);
      end
    end
    if (out_load) begin
      out_fib_value_r <= acc_r[0];
    end
  end

`ifndef SYNTHESIS
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fib_value_r != fibmp_pkg::FIB_P))
    else $error("result not reduced");

  a_drained_at_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ((pc_r == fibmp_pkg::STEP_COMMIT_ACC) || (pc_r == fibmp_pkg::STEP_COMMIT_PW)))
    |-> (!pipe1_r.vld && !pipe2_r.vld && !pipe3_r.vld))
    else $error("commit while products in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("accepted item not in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_fib_value_r)))
    else $error("stalled result changed");
`endif

endmodule
